// File: hdl/irn_pkg.sv
// Shared types, constants and the microprogram of the Roman numeral converter.
package irn_pkg;

    localparam int NumW  = 12;
    localparam int CharW = 7;
    localparam int ValW  = 10;
    localparam int PcW   = 5;

    localparam logic [NumW-1:0] MAX_VALID = 12'd3999;

    // Micro-operations.
    localparam logic [1:0] OP_LOOP = 2'd0;
    localparam logic [1:0] OP_PAIR = 2'd1;
    localparam logic [1:0] OP_TAIL = 2'd2;
    localparam logic [1:0] OP_ERR  = 2'd3;

    localparam logic [PcW-1:0] PC_FIRST = 5'd0;
    localparam logic [PcW-1:0] PC_ERR   = 5'd19;

    // ASCII codes of the numeral letters.
    localparam logic [CharW-1:0] CH_NONE = 7'h00;
    localparam logic [CharW-1:0] CH_I    = 7'h49;
    localparam logic [CharW-1:0] CH_V    = 7'h56;
    localparam logic [CharW-1:0] CH_X    = 7'h58;
    localparam logic [CharW-1:0] CH_L    = 7'h4C;
    localparam logic [CharW-1:0] CH_C    = 7'h43;
    localparam logic [CharW-1:0] CH_D    = 7'h44;
    localparam logic [CharW-1:0] CH_M    = 7'h4D;

    typedef struct packed {
        logic [1:0]       op;
        logic [ValW-1:0]  value;
        logic [CharW-1:0] letter;
        logic [PcW-1:0]   target;
    } t_uword;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        logic             busy;
        logic [1:0]       op;
        logic [ValW-1:0]  value;
        logic [CharW-1:0] letter;
    } t_uctl;

    // Status from the datapath back to the sequencer.
    typedef struct packed {
        logic ge;
        logic emit;
        logic last;
    } t_ustat;

    function automatic t_uword f_uw(input logic [1:0] op, input logic [ValW-1:0] value,
                                    input logic [CharW-1:0] letter,
                                    input logic [PcW-1:0] target);
        t_uword w;
        w.op     = op;
        w.value  = value;
        w.letter = letter;
        w.target = target;
        return w;
    endfunction

    // A loop step emits its letter while the rest covers its value. A pair step
    // emits the first letter of a subtractive pair or jumps past the pair; the
    // tail step that follows emits the second letter.
    function automatic t_uword f_urom(input logic [PcW-1:0] pc);
        t_uword w;
        case (pc)
            5'd0:    w = f_uw(OP_LOOP, 10'd1000, CH_M, 5'd0);
            5'd1:    w = f_uw(OP_PAIR, 10'd900,  CH_C, 5'd3);
            5'd2:    w = f_uw(OP_TAIL, 10'd0,    CH_M, 5'd0);
            5'd3:    w = f_uw(OP_LOOP, 10'd500,  CH_D, 5'd0);
            5'd4:    w = f_uw(OP_PAIR, 10'd400,  CH_C, 5'd6);
            5'd5:    w = f_uw(OP_TAIL, 10'd0,    CH_D, 5'd0);
            5'd6:    w = f_uw(OP_LOOP, 10'd100,  CH_C, 5'd0);
            5'd7:    w = f_uw(OP_PAIR, 10'd90,   CH_X, 5'd9);
            5'd8:    w = f_uw(OP_TAIL, 10'd0,    CH_C, 5'd0);
            5'd9:    w = f_uw(OP_LOOP, 10'd50,   CH_L, 5'd0);
            5'd10:   w = f_uw(OP_PAIR, 10'd40,   CH_X, 5'd12);
            5'd11:   w = f_uw(OP_TAIL, 10'd0,    CH_L, 5'd0);
            5'd12:   w = f_uw(OP_LOOP, 10'd10,   CH_X, 5'd0);
            5'd13:   w = f_uw(OP_PAIR, 10'd9,    CH_I, 5'd15);
            5'd14:   w = f_uw(OP_TAIL, 10'd0,    CH_X, 5'd0);
            5'd15:   w = f_uw(OP_LOOP, 10'd5,    CH_V, 5'd0);
            5'd16:   w = f_uw(OP_PAIR, 10'd4,    CH_I, 5'd18);
            5'd17:   w = f_uw(OP_TAIL, 10'd0,    CH_V, 5'd0);
            5'd18:   w = f_uw(OP_LOOP, 10'd1,    CH_I, 5'd0);
            default: w = f_uw(OP_ERR,  10'd0,    CH_NONE, 5'd0);
        endcase
        return w;
    endfunction

endpackage

// File: hdl/irn_if.sv
// Valid/ready stream interfaces for the number input and the character output.
interface irn_num_if
    import irn_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [NumW-1:0] number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);
endinterface

interface irn_sym_if
    import irn_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CharW-1:0] symbol_char;
    logic             last_char;
    logic             range_error;

    modport source (output valid, output symbol_char, output last_char,
                    output range_error, input ready);
    modport sink   (input valid, input symbol_char, input last_char,
                    input range_error, output ready);
endinterface

// File: hdl/irn_useq.sv
// Microprogram sequencer: step counter, control store lookup and branching.
module irn_useq
    import irn_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_start,
    input  logic   i_start_err,
    input  t_ustat i_stat,
    output t_uctl  o_ctl,
    output logic   o_busy
);

    logic [PcW-1:0] r_pc, n_pc;
    logic           r_busy, n_busy;
    t_uword         w_word;

    assign w_word = f_urom(r_pc);

    assign o_ctl.busy   = r_busy;
    assign o_ctl.op     = w_word.op;
    assign o_ctl.value  = w_word.value;
    assign o_ctl.letter = w_word.letter;
    assign o_busy       = r_busy;

    always_comb begin
        n_pc   = r_pc;
        n_busy = r_busy;
        if (!r_busy) begin
            if (i_start) begin
                n_busy = 1'b1;
                n_pc   = i_start_err ? PC_ERR : PC_FIRST;
            end
        end else begin
            case (w_word.op)
                OP_LOOP: begin
                    if (i_stat.emit && i_stat.last) begin
                        n_busy = 1'b0;
                    end else if (!i_stat.ge) begin
                        n_pc = r_pc + PcW'(1);
                    end
                end
                OP_PAIR: begin
                    if (i_stat.emit) begin
                        n_pc = r_pc + PcW'(1);
                    end else if (!i_stat.ge) begin
                        n_pc = w_word.target;
                    end
                end
                OP_TAIL: begin
                    if (i_stat.emit) begin
                        if (i_stat.last) begin
                            n_busy = 1'b0;
                        end else begin
                            n_pc = r_pc + PcW'(1);
                        end
                    end
                end
                OP_ERR: begin
                    if (i_stat.emit) begin
                        n_busy = 1'b0;
                    end
                end
                default: begin
                    n_busy = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= PC_FIRST;
            r_busy <= 1'b0;
        end else begin
            r_pc   <= n_pc;
            r_busy <= n_busy;
        end
    end

endmodule

// File: hdl/irn_dpath.sv
// Datapath: remaining value, compare and subtract, and the output register.
module irn_dpath
    import irn_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic [NumW-1:0]  i_number,
    input  t_uctl            i_ctl,
    input  logic             i_out_ready,
    output t_ustat           o_stat,
    output logic             o_out_valid,
    output logic [CharW-1:0] o_symbol_char,
    output logic             o_last_char,
    output logic             o_range_error
);

    logic [NumW-1:0]  r_rest;
    logic [NumW-1:0]  w_value;
    logic [NumW-1:0]  w_diff;
    logic             w_ge;
    logic             w_req;
    logic             w_last;
    logic             w_emit;
    logic             w_out_free;
    logic             r_out_valid;
    logic [CharW-1:0] r_symbol_char;
    logic             r_last_char;
    logic             r_range_error;

    assign w_value    = NumW'(i_ctl.value);
    assign w_ge       = (r_rest >= w_value);
    assign w_diff     = r_rest - w_value;
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        case (i_ctl.op)
            OP_LOOP: begin
                w_req  = w_ge;
                w_last = (w_diff == '0);
            end
            OP_PAIR: begin
                w_req  = w_ge;
                w_last = 1'b0;
            end
            OP_TAIL: begin
                w_req  = 1'b1;
                w_last = (w_diff == '0);
            end
            OP_ERR: begin
                w_req  = 1'b1;
                w_last = 1'b1;
            end
            default: begin
                w_req  = 1'b0;
                w_last = 1'b0;
            end
        endcase
    end

    assign w_emit = i_ctl.busy && w_out_free && w_req;

    assign o_stat.ge   = w_ge;
    assign o_stat.emit = w_emit;
    assign o_stat.last = w_last;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rest <= i_number;
        end else if (w_emit && (i_ctl.op inside {OP_LOOP, OP_PAIR})) begin
            r_rest <= w_diff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_symbol_char <= i_ctl.letter;
            r_last_char   <= w_last;
            r_range_error <= (i_ctl.op == OP_ERR);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_symbol_char = r_symbol_char;
    assign o_last_char   = r_last_char;
    assign o_range_error = r_range_error;

endmodule

// File: hdl/integer_to_roman_numeral.sv
// Top level of the integer to Roman numeral converter.
//
// The block takes one 12-bit unsigned number per item on i_num and returns its
// Roman numeral on o_sym as a run of ASCII characters, most significant first,
// one character per item. The final character of a run carries last_char.
// A number of 0 or above 3999 yields one item with symbol_char 0, last_char
// and range_error set.
// A number is taken when i_num.ready is high, which is whenever no conversion
// is in progress. Each microprogram step either emits a character or moves on
// to a later table entry without emitting, so the first character reaches
// o_sym later for each test passed over before it (twelve for a number of 1).
// The next number can be taken once the last character has been registered.
// The single output register lets that next number start while the last
// character still waits. When the receiver stalls, the sequencer holds on the
// step that wants to emit; steps that only skip table entries keep going.
// Synchronous reset clears the sequencer and drops o_sym.valid.
module integer_to_roman_numeral
    import irn_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    irn_num_if.sink    i_num,
    irn_sym_if.source  o_sym
);

    t_uctl  w_ctl;
    t_ustat w_stat;
    logic   w_busy;
    logic   w_accept;
    logic   w_bad_number;

    // A new number is taken only between conversions.
    assign i_num.ready  = !w_busy;
    assign w_accept     = i_num.valid && !w_busy;
    assign w_bad_number = (i_num.number == '0) || (i_num.number > MAX_VALID);

    irn_useq u_useq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_accept),
        .i_start_err (w_bad_number),
        .i_stat      (w_stat),
        .o_ctl       (w_ctl),
        .o_busy      (w_busy)
    );

    irn_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_accept),
        .i_number      (i_num.number),
        .i_ctl         (w_ctl),
        .i_out_ready   (o_sym.ready),
        .o_stat        (w_stat),
        .o_out_valid   (o_sym.valid),
        .o_symbol_char (o_sym.symbol_char),
        .o_last_char   (o_sym.last_char),
        .o_range_error (o_sym.range_error)
    );

`ifndef SYNTHESIS
    // A taken number always starts a conversion.
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> w_busy)
        else $error("accepted number did not start a conversion");

    // An error item is a lone, blank, final character.
    a_error_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_sym.valid && o_sym.range_error) |-> (o_sym.last_char && o_sym.symbol_char == CH_NONE))
        else $error("error item is not a blank last character");

    // A conversion ends exactly when its last character is registered.
    a_end_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(w_busy) |-> (o_sym.valid && o_sym.last_char))
        else $error("conversion ended without a last character");
`endif

endmodule
